/* rtl/mqde_pkg.sv */
// ----------------------------------------------------------------------------
// Multi-queue deque engine package
// Operation and status codes and the fixed field widths of the item ports.
// ----------------------------------------------------------------------------
package mqde_pkg;

  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int QID_W    = 4;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_SIZE       = 3'd4,
    OP_FRONT      = 3'd5,
    OP_BACK       = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_DATA  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

endpackage

/* rtl/mqde_ram.sv */
// ----------------------------------------------------------------------------
// Multi-queue deque element store
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mqde_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // The read data holds until the next read, so a stalled result keeps it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/multi_queue_deque_engine_core.sv */
// ----------------------------------------------------------------------------
// Multi-queue deque engine
// Several double-ended queues, each a ring of QUEUE_DEPTH entries in one
// shared element store, served one operation per item.
// ----------------------------------------------------------------------------
// Flow: the edge that accepts an item loads the input register, and the item
// moves on into the result register at the first edge where that stage is
// free; the result is then valid until it is taken with out_stall low.
// Throughput: one item per cycle while out_stall is low, set by the single
// ring-pointer update and the at most one store access each item makes.
// Reset clears every head index, every element count and the valid flags of
// both pipeline stages; the element store is not cleared and needs no clearing time.
module multi_queue_deque_engine_core #(
  parameter int NUM_QUEUES  = 16,
  parameter int QUEUE_DEPTH = 64,
  parameter int VALUE_BITS  = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [mqde_pkg::OP_W-1:0]            in_operation,
  input  logic [mqde_pkg::QID_W-1:0]           in_queue_id,
  input  logic signed [mqde_pkg::DATA_W-1:0]   in_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mqde_pkg::DATA_W-1:0]   out_data,
  output logic [mqde_pkg::STATUS_W-1:0]        out_status
);

  import mqde_pkg::*;

  // Ring index, element count, queue index and store address widths.
  localparam int HW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SW    = CW + 1;
  localparam int QIW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SLOTS = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW    = $clog2(SLOTS);

  // Per-queue pointers live in flip-flops so that reset clears them at once.
  logic [HW-1:0] head_r [NUM_QUEUES];
  logic [CW-1:0] cnt_r  [NUM_QUEUES];

  // Input register stage: the item waiting to be executed.
  logic                     a_valid_r, a_valid_nxt;
  op_t                      a_op_r;
  logic [QID_W-1:0]         a_qid_r;
  logic signed [DATA_W-1:0] a_value_r;

  // Result register stage.
  logic                     out_valid_r;
  status_t                  b_status_r, b_status_nxt;
  logic signed [DATA_W-1:0] b_data_r, b_data_nxt;
  logic                     b_use_mem_r, b_use_mem_nxt;

  logic b_ready;
  logic fire_a;
  logic accept;

  // The result stage frees up whenever its item is taken or it is empty;
  // the input stage executes its item at that same edge.
  assign b_ready  = !out_valid_r || !out_stall;
  assign fire_a   = a_valid_r && b_ready;
  assign in_stall = a_valid_r && !b_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (accept) begin
      a_valid_nxt = 1'b1;
    end else if (fire_a) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_op_r    <= op_t'(in_operation);
      a_qid_r   <= in_queue_id;
      a_value_r <= in_value;
    end
  end

  // ---------------------------------------------------------------------------
  // Execute: read the addressed queue's pointers, pick the ring slot, update.
  // ---------------------------------------------------------------------------
  logic            q_hit;
  logic [QIW-1:0]  qi;
  logic [HW-1:0]   h;
  logic [CW-1:0]   c;
  logic            empty;
  logic            full;
  logic [SW-1:0]   tail_sum;
  logic [SW-1:0]   last_sum;
  logic [HW-1:0]   tail_pos;
  logic [HW-1:0]   last_pos;
  logic [HW-1:0]   h_dec;
  logic [HW-1:0]   h_inc;
  logic [AW-1:0]   base_addr;
  logic [HW-1:0]   pos;
  logic [AW-1:0]   slot_addr;
  logic [HW-1:0]   head_nxt;
  logic [CW-1:0]   cnt_nxt;
  logic            ptr_wr;
  logic            mem_wr;
  logic            mem_rd;

  logic signed [VALUE_BITS-1:0] wr_val;
  logic signed [VALUE_BITS-1:0] ram_rd_data;

  // Queue numbers at or above NUM_QUEUES finish with done and no effect.
  assign q_hit = (32'(a_qid_r) < 32'(NUM_QUEUES));
  assign qi    = QIW'(a_qid_r);
  assign h     = head_r[qi];
  assign c     = cnt_r[qi];
  assign empty = (c == '0);
  assign full  = (c == CW'(QUEUE_DEPTH));

  // Both sums stay below twice the depth, so one conditional subtract wraps.
  assign tail_sum = SW'(h) + SW'(c);
  assign last_sum = SW'(h) + SW'(c) - SW'(1);
  assign tail_pos = (tail_sum >= SW'(QUEUE_DEPTH)) ? HW'(tail_sum - SW'(QUEUE_DEPTH))
                                                   : HW'(tail_sum);
  assign last_pos = (last_sum >= SW'(QUEUE_DEPTH)) ? HW'(last_sum - SW'(QUEUE_DEPTH))
                                                   : HW'(last_sum);
  assign h_dec    = (h == '0) ? HW'(QUEUE_DEPTH - 1) : h - HW'(1);
  assign h_inc    = (h == HW'(QUEUE_DEPTH - 1)) ? '0 : h + HW'(1);

  assign base_addr = AW'(AW'(qi) * AW'(QUEUE_DEPTH));
  assign slot_addr = base_addr + AW'(pos);

  // Stored elements are the pushed value sign-extended or cut to VALUE_BITS.
  assign wr_val = VALUE_BITS'(a_value_r);

  always_comb begin
    b_status_nxt  = ST_DONE;
    b_data_nxt    = '0;
    b_use_mem_nxt = 1'b0;
    head_nxt      = h;
    cnt_nxt       = c;
    pos           = h;
    ptr_wr        = 1'b0;
    mem_wr        = 1'b0;
    mem_rd        = 1'b0;
    if (q_hit) begin
      case (a_op_r)
        OP_PUSH_BACK: begin
          if (full) begin
            b_status_nxt = ST_FULL;
          end else begin
            pos     = tail_pos;
            cnt_nxt = c + CW'(1);
            ptr_wr  = 1'b1;
            mem_wr  = 1'b1;
          end
        end
        OP_PUSH_FRONT: begin
          if (full) begin
            b_status_nxt = ST_FULL;
          end else begin
            pos      = h_dec;
            head_nxt = h_dec;
            cnt_nxt  = c + CW'(1);
            ptr_wr   = 1'b1;
            mem_wr   = 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            b_status_nxt = ST_EMPTY;
          end else begin
            cnt_nxt = c - CW'(1);
            ptr_wr  = 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            b_status_nxt = ST_EMPTY;
          end else begin
            head_nxt = h_inc;
            cnt_nxt  = c - CW'(1);
            ptr_wr   = 1'b1;
          end
        end
        OP_SIZE: begin
          b_status_nxt = ST_DATA;
          b_data_nxt   = DATA_W'(c);
        end
        OP_FRONT, OP_BACK: begin
          if (empty) begin
            b_status_nxt = ST_EMPTY;
          end else begin
            pos           = (a_op_r == OP_FRONT) ? h : last_pos;
            b_status_nxt  = ST_DATA;
            b_use_mem_nxt = 1'b1;
            mem_rd        = 1'b1;
          end
        end
        default: begin
          // The unused operation code finishes with no effect.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else if (fire_a && ptr_wr) begin
      head_r[qi] <= head_nxt;
      cnt_r[qi]  <= cnt_nxt;
    end
  end

  mqde_ram #(
    .DEPTH (SLOTS),
    .AW    (AW),
    .DW    (VALUE_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (fire_a && mem_wr),
    .wr_addr (slot_addr),
    .wr_data (wr_val),
    .rd_en   (fire_a && mem_rd),
    .rd_addr (slot_addr),
    .rd_data (ram_rd_data)
  );

  // ---------------------------------------------------------------------------
  // Result stage. Front and back take their data from the store's read
  // register, which only changes when a new item moves into this stage.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_ready) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_a) begin
      b_status_r  <= b_status_nxt;
      b_data_r    <= b_data_nxt;
      b_use_mem_r <= b_use_mem_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = b_status_r;
  assign out_data   = b_use_mem_r ? DATA_W'(ram_rd_data) : b_data_r;

endmodule

/* rtl/mqde_checker.sv */
// ----------------------------------------------------------------------------
// Multi-queue deque engine port checker
// Watches the top level's ports and flags timing and result-format slips.
// ----------------------------------------------------------------------------
module mqde_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [mqde_pkg::DATA_W-1:0]   out_data,
  input logic [mqde_pkg::STATUS_W-1:0]        out_status
);

  import mqde_pkg::*;

  // A result that appears after an idle output follows an accepted item, with only the input register between them.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result appeared without an item accepted two cycles before");

  // The input only backs up behind a stalled result.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output was free");

  // Only results that carry data have a nonzero data field.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_DATA)) |-> (out_data == '0))
    else $error("nonzero data on a result without data");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data) && $stable(out_status)))
    else $error("stalled result changed");

endmodule

bind multi_queue_deque_engine_core mqde_checker u_mqde_checker (.*);

/* verif/tb_multi_queue_deque_engine_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the multi-queue deque engine
// Drives push, pop, size, front and back operations over all sixteen
// queues and predicts every result from a local copy of the rings, head
// indexes and element counts. Each result is checked field by field.
// ----------------------------------------------------------------------------
module tb_multi_queue_deque_engine_core;
  import mqde_pkg::*;

  localparam int NQ    = 16;
  localparam int DEPTH = 64;

  // Operation code seven has no meaning; the block answers it with done.
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    status_t                  status;
  } result_t;

  // Clock and reset. Reset is asserted once, at the start.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Every block input starts at a known value.
  logic                     in_valid     = 1'b0;
  logic [OP_W-1:0]          in_operation = '0;
  logic [QID_W-1:0]         in_queue_id  = '0;
  logic signed [DATA_W-1:0] in_value     = '0;
  logic                     out_stall    = 1'b0;
  logic                     in_stall;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_data;
  logic [STATUS_W-1:0]      out_status;

  multi_queue_deque_engine_core #(
    .NUM_QUEUES (NQ),
    .QUEUE_DEPTH(DEPTH),
    .VALUE_BITS (32)
  ) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_operation(in_operation),
    .in_queue_id (in_queue_id),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .out_status  (out_status)
  );

  // Local copy of the deque state. Only entries inside a queue's count are
  // ever read, and those have always been written by an earlier push.
  logic [DATA_W-1:0] ring_store [NQ][DEPTH];
  logic [5:0]        head_ptr [NQ];
  logic [6:0]        fill_cnt [NQ];

  result_t pending_results[$];
  int      mismatch_count = 0;

  // When set, the sender leaves gaps and the receiver stalls, both in bursts.
  bit idle_on = 1'b1;

  // Applies one operation to the local deque state and returns the result the
  // block must give for it.
  function automatic result_t apply_deque_op(input logic [OP_W-1:0] op,
                                             input logic [QID_W-1:0] qid,
                                             input logic [DATA_W-1:0] val);
    result_t    r;
    logic [5:0] h;
    logic [6:0] c;
    logic [5:0] pos;
    r.data   = '0;
    r.status = ST_DONE;
    h = head_ptr[qid];
    c = fill_cnt[qid];
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (c == 7'(DEPTH)) begin
          // A full ring drops the push and leaves the state alone.
          r.status = ST_FULL;
        end else if (op == OP_PUSH_BACK) begin
          pos = h + c[5:0];
          ring_store[qid][pos] = val;
          fill_cnt[qid] = c + 7'd1;
        end else begin
          h = h - 6'd1;
          ring_store[qid][h] = val;
          head_ptr[qid] = h;
          fill_cnt[qid] = c + 7'd1;
        end
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (c == 7'd0) begin
          r.status = ST_EMPTY;
        end else begin
          if (op == OP_POP_FRONT) head_ptr[qid] = h + 6'd1;
          fill_cnt[qid] = c - 7'd1;
        end
      end
      OP_SIZE: begin
        r.data   = DATA_W'(c);
        r.status = ST_DATA;
      end
      OP_FRONT, OP_BACK: begin
        if (c == 7'd0) begin
          r.status = ST_EMPTY;
        end else begin
          pos = (op == OP_FRONT) ? h : h + c[5:0] - 6'd1;
          r.data   = ring_store[qid][pos];
          r.status = ST_DATA;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Pushed values lean toward the signed extremes, zero and minus one.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Sends one item. Valid is only lowered at the start of a gap, so an item
  // that follows directly keeps valid high without a second assignment in
  // the same step. The prediction is made at the edge where the item is
  // taken, which keeps the expected results in acceptance order.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [QID_W-1:0] qid,
                           input logic [DATA_W-1:0] val);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_queue_id  <= qid;
    in_value     <= val;
    do @(posedge clk); while (in_stall);
    pending_results.insert(pending_results.size(), apply_deque_op(op, qid, val));
  endtask

  // The receiver stalls in bursts while idling is on. A burst in progress
  // ends early once idling is switched off.
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) begin
          if (idle_on) @(posedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker: every accepted result is matched with the oldest
  // expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: data %0d status %0d", out_data, out_status);
        mismatch_count++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (out_data !== want.data) begin
          $error("data: expected %0d, actual %0d", want.data, out_data);
          mismatch_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          mismatch_count++;
        end
      end
    end
  end

  // Empty queue handling, the unused operation code, value extremes and the
  // basic push, pop and inspect operations at both ends.
  task automatic test_directed();
    send_item(OP_POP_BACK,   4'd0, $urandom);
    send_item(OP_POP_FRONT,  4'd0, $urandom);
    send_item(OP_FRONT,      4'd0, $urandom);
    send_item(OP_BACK,       4'd0, $urandom);
    send_item(OP_SIZE,       4'd0, $urandom);
    send_item(OP_UNUSED,     4'd15, 32'hFFFF_FFFF);
    send_item(OP_PUSH_BACK,  4'd0, 32'h7FFF_FFFF);
    send_item(OP_PUSH_FRONT, 4'd0, 32'h8000_0000);
    send_item(OP_PUSH_BACK,  4'd0, 32'h0000_0000);
    send_item(OP_PUSH_FRONT, 4'd0, 32'hFFFF_FFFF);
    send_item(OP_SIZE,       4'd0, $urandom);
    send_item(OP_FRONT,      4'd0, $urandom);
    send_item(OP_BACK,       4'd0, $urandom);
    send_item(OP_POP_FRONT,  4'd0, $urandom);
    send_item(OP_POP_BACK,   4'd0, $urandom);
    send_item(OP_FRONT,      4'd0, $urandom);
    send_item(OP_BACK,       4'd0, $urandom);
    send_item(OP_PUSH_BACK,  4'd15, 32'h5555_AAAA);
    send_item(OP_BACK,       4'd15, $urandom);
    send_item(OP_POP_FRONT,  4'd15, $urandom);
    send_item(OP_SIZE,       4'd15, $urandom);
  endtask

  // Fills one queue from both ends until it is full, tries pushes that must
  // be dropped, then drains it and pops at both ends on the empty queue. The
  // head index wraps around the ring on the way.
  task automatic test_full_queue(input logic [QID_W-1:0] qid);
    while (fill_cnt[qid] < 7'(DEPTH))
      send_item($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, qid, pick_value());
    send_item(OP_PUSH_BACK,  qid, pick_value());
    send_item(OP_PUSH_FRONT, qid, pick_value());
    send_item(OP_SIZE,       qid, $urandom);
    send_item(OP_FRONT,      qid, $urandom);
    send_item(OP_BACK,       qid, $urandom);
    while (fill_cnt[qid] != 7'd0) begin
      send_item($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, qid, $urandom);
      if ($urandom_range(0, 3) == 0)
        send_item($urandom_range(0, 1) ? OP_FRONT : OP_BACK, qid, $urandom);
    end
    send_item(OP_POP_BACK,  qid, $urandom);
    send_item(OP_POP_FRONT, qid, $urandom);
    send_item(OP_SIZE,      qid, $urandom);
  endtask

  // Random traffic in segments. Each segment works on one to three queues
  // and leans toward filling, draining or a balanced mix, so the queues
  // swing between empty and full. A small share of items is noise: any
  // operation code, the unused one included, on any queue.
  task automatic test_random_traffic(input int n_items);
    int               sent;
    int               seg_len;
    int               push_end;
    int               pop_end;
    int               n_focus;
    int               roll;
    logic [QID_W-1:0] focus [3];
    logic [OP_W-1:0]  op;
    logic [QID_W-1:0] qid;
    sent = 0;
    while (sent < n_items) begin
      seg_len = $urandom_range(60, 200);
      n_focus = $urandom_range(1, 3);
      for (int i = 0; i < 3; i++) focus[i] = QID_W'($urandom_range(0, NQ - 1));
      case ($urandom_range(0, 2))
        0: begin push_end = 85; pop_end = 95; end
        1: begin push_end = 20; pop_end = 85; end
        default: begin push_end = 45; pop_end = 80; end
      endcase
      for (int k = 0; k < seg_len && sent < n_items; k++) begin
        qid  = focus[$urandom_range(0, n_focus - 1)];
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          op  = OP_W'($urandom_range(0, 7));
          qid = QID_W'($urandom_range(0, NQ - 1));
        end else if (roll < push_end) begin
          op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        end else if (roll < pop_end) begin
          op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        end else begin
          case ($urandom_range(0, 2))
            0:       op = OP_SIZE;
            1:       op = OP_FRONT;
            default: op = OP_BACK;
          endcase
        end
        send_item(op, qid, (op == OP_PUSH_BACK || op == OP_PUSH_FRONT) ?
                  pick_value() : $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    for (int q = 0; q < NQ; q++) begin
      head_ptr[q] = '0;
      fill_cnt[q] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_full_queue(4'd9);
    test_random_traffic(1380);
    // The last stretch runs with neither gaps nor stalls.
    idle_on = 1'b0;
    test_random_traffic(200);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    // A final wait catches any result the block gives beyond the last one.
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
rtl/mqde_pkg.sv
rtl/mqde_ram.sv
rtl/multi_queue_deque_engine_core.sv
rtl/mqde_checker.sv
verif/tb_multi_queue_deque_engine_core.sv
